FILE: rtl/cgls_pkg.sv
// ============================================================================
// Complex grid Laplacian stencil package
// Shared types, register indexes, stencil weights and divisors.
// ============================================================================
package cgls_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY = 2'd3;

    localparam logic [1:0]  ORDER_RESET  = 2'd1;
    localparam logic [6:0]  STRIDE_RESET = 7'd64;
    localparam logic [31:0] INV_RESET    = 32'd65536;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Signed width used for neighbour address arithmetic and bound checks.
    localparam int ADDR_CALC_W = 19;
    localparam int PROD_W      = 128;
    localparam int QUOT_W      = 96;
    localparam int DIGIT_W     = 8;
    localparam int DIV_STEPS   = QUOT_W / DIGIT_W;
    localparam int TERM_W      = 98;
    localparam int WEIGHT_W    = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_SQUARE,
        ST_MULT,
        ST_DIVIDE,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       wr;
        logic       rd;
        logic       axis;
        logic [2:0] pt;
        logic       square;
        logic       mult;
        logic       div;
        logic       div_first;
        logic       accum;
        logic       finish;
        logic [1:0] term;
        logic [1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] order;
        logic       err;
    } dp_status_t;

    // Integer stencil weight for tap distance k, scaled over the divisor.
    function automatic logic signed [WEIGHT_W-1:0] stencil_weight(
        input logic [1:0] ord,
        input logic [1:0] k
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        case (ord)
            2'd1:
            begin
                case (k)
                    2'd0:    w = -11'sd2;
                    2'd1:    w = 11'sd1;
                    default: w = '0;
                endcase
            end
            2'd2:
            begin
                case (k)
                    2'd0:    w = -11'sd30;
                    2'd1:    w = 11'sd16;
                    2'd2:    w = -11'sd1;
                    default: w = '0;
                endcase
            end
            2'd3:
            begin
                case (k)
                    2'd0:    w = -11'sd490;
                    2'd1:    w = 11'sd270;
                    2'd2:    w = -11'sd27;
                    default: w = 11'sd2;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [DIGIT_W-1:0] stencil_divisor(input logic [1:0] ord);
        logic [DIGIT_W-1:0] d;
        case (ord)
            2'd2:    d = 8'd12;
            2'd3:    d = 8'd180;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/cgls_ctrl.sv
// ============================================================================
// Complex grid Laplacian stencil controller
// Sequences reads, scaling multiplies, divides and accumulation of a query.
// ============================================================================
module cgls_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                req_type,
    input  cgls_pkg::dp_status_t status,
    output cgls_pkg::dp_cmd_t   cmd,
    output logic                busy
);
    import cgls_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] pt_reg, pt_next;
    logic       axis_reg, axis_next;
    logic [1:0] term_reg, term_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] last_pt;

    assign last_pt = {status.order, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pt_reg    <= '0;
            axis_reg  <= 1'b0;
            term_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            axis_reg  <= axis_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pt_next    = pt_reg;
        axis_next  = axis_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && req_type == REQ_QUERY)
                begin
                    pt_next    = '0;
                    axis_next  = 1'b0;
                    term_next  = '0;
                    state_next = (status.order == 2'd0) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:
            begin
                if (pt_reg == last_pt)
                begin
                    pt_next = '0;
                    if (axis_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        axis_next = 1'b1;
                    end
                end
                else
                begin
                    pt_next = pt_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = status.err ? ST_FINISH : ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cnt_next   = '0;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_ACCUM:
            begin
                if (term_reg == 2'd3)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.pt        = pt_reg;
        cmd.term      = term_reg;
        cmd.cnt       = cnt_reg[1:0];
        busy          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start && (req_type == REQ_QUERY);
                cmd.wr   = start && (req_type == REQ_WRITE);
            end
            ST_READ:   cmd.rd = 1'b1;
            ST_SQUARE: cmd.square = 1'b1;
            ST_MULT:   cmd.mult = 1'b1;
            ST_DIVIDE:
            begin
                cmd.div       = 1'b1;
                cmd.div_first = (cnt_reg == 4'd0);
            end
            ST_ACCUM:  cmd.accum = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            default:   cmd.load = 1'b0;
        endcase
    end

endmodule

FILE: rtl/cgls_datapath.sv
// ============================================================================
// Complex grid Laplacian stencil datapath
// Sample stores, configuration, weighted sums, scaling and saturation.
// ============================================================================
module cgls_datapath
#(
    parameter int GRID_WORDS  = 4096,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cgls_pkg::dp_cmd_t                   cmd,
    output cgls_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [cgls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cgls_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [5:0]                          row,
    input  logic [5:0]                          col,
    input  logic signed [31:0]                  sample_re,
    input  logic signed [31:0]                  sample_im,
    output logic                                done,
    output logic signed [63:0]                  lap_re,
    output logic signed [63:0]                  lap_im,
    output logic                                addr_error
);
    import cgls_pkg::*;

    localparam int AW = $clog2(GRID_WORDS);
    localparam int WW = SAMPLE_BITS + 12;

    logic [1:0]  order_reg;
    logic [6:0]  stride_reg;
    logic [31:0] inv_dx_reg;
    logic [31:0] inv_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ORDER_RESET;
            stride_reg <= STRIDE_RESET;
            inv_dx_reg <= INV_RESET;
            inv_dy_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORDER:  order_reg  <= cfg_data[1:0];
                CFG_STRIDE: stride_reg <= cfg_data[6:0];
                CFG_INV_DX: inv_dx_reg <= cfg_data;
                CFG_INV_DY: inv_dy_reg <= cfg_data;
                default:    order_reg  <= order_reg;
            endcase
        end
    end

    // Addressing: the write address is row * stride + col, from the ports and the stride register.
    logic signed [ADDR_CALC_W-1:0] grid_limit;
    logic signed [ADDR_CALC_W-1:0] base_in;
    logic signed [ADDR_CALC_W-1:0] base_reg;
    logic signed [ADDR_CALC_W-1:0] rd_addr;
    logic [1:0]                    tap_k;
    logic [6:0]                    tap_step;
    logic [8:0]                    tap_off;
    logic                          base_ok;
    logic                          rd_ok;
    logic signed [63:0]            ext_re;
    logic signed [63:0]            ext_im;

    assign grid_limit = ADDR_CALC_W'(GRID_WORDS);
    assign base_in    = ADDR_CALC_W'(row) * ADDR_CALC_W'(stride_reg) + ADDR_CALC_W'(col);
    assign base_ok    = (base_in < grid_limit);
    assign tap_k      = 2'((cmd.pt + 3'd1) >> 1);
    assign tap_step   = cmd.axis ? 7'd1 : stride_reg;
    assign tap_off    = 9'(tap_k) * 9'(tap_step);
    assign rd_addr    = cmd.pt[0] ? base_reg + ADDR_CALC_W'(tap_off)
                                  : base_reg - ADDR_CALC_W'(tap_off);
    assign rd_ok      = (rd_addr >= 0) && (rd_addr < grid_limit);
    assign ext_re     = 64'(sample_re);
    assign ext_im     = 64'(sample_im);

    logic [SAMPLE_BITS-1:0] real_store [GRID_WORDS];
    logic [SAMPLE_BITS-1:0] imag_store [GRID_WORDS];
    logic signed [SAMPLE_BITS-1:0] re_q_reg;
    logic signed [SAMPLE_BITS-1:0] im_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr && base_ok)
        begin
            real_store[base_in[AW-1:0]] <= ext_re[SAMPLE_BITS-1:0];
            imag_store[base_in[AW-1:0]] <= ext_im[SAMPLE_BITS-1:0];
        end
        if (cmd.rd)
        begin
            re_q_reg <= real_store[rd_addr[AW-1:0]];
            im_q_reg <= imag_store[rd_addr[AW-1:0]];
        end
    end

    // Weighted sums, one per axis and part.
    logic                       rvalid_reg;
    logic                       raxis_reg;
    logic                       err_reg;
    logic signed [WEIGHT_W-1:0] wt_reg;
    logic signed [WW-1:0]       wx_re_reg, wx_im_reg, wy_re_reg, wy_im_reg;
    logic signed [WW-1:0]       pr_re, pr_im;

    assign pr_re = WW'(wt_reg) * WW'(re_q_reg);
    assign pr_im = WW'(wt_reg) * WW'(im_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.rd;
            if (cmd.load)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.rd && !rd_ok)
            begin
                err_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raxis_reg <= cmd.axis;
        wt_reg    <= stencil_weight(order_reg, tap_k);
        if (cmd.load)
        begin
            base_reg  <= base_in;
            wx_re_reg <= '0;
            wx_im_reg <= '0;
            wy_re_reg <= '0;
            wy_im_reg <= '0;
        end
        else if (rvalid_reg)
        begin
            if (raxis_reg)
            begin
                wy_re_reg <= wy_re_reg + pr_re;
                wy_im_reg <= wy_im_reg + pr_im;
            end
            else
            begin
                wx_re_reg <= wx_re_reg + pr_re;
                wx_im_reg <= wx_im_reg + pr_im;
            end
        end
    end

    // Scaling of one term: |W| * inv^2, then divided by D * 2^32.
    logic signed [WW-1:0] w_sel;
    logic [63:0]          inv2_reg;
    logic [63:0]          mag_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          pp;
    logic [PROD_W-1:0]    pp_shifted;
    logic [QUOT_W-1:0]    div_reg;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   dvs;
    logic [QUOT_W-1:0]    div_src;
    logic [DIGIT_W:0]     part;
    logic [DIGIT_W-1:0]   qdig;
    logic signed [TERM_W-1:0] term_val;
    logic signed [TERM_W-1:0] sum_re_reg, sum_im_reg;

    always_comb
    begin
        case (cmd.term)
            2'd0:    w_sel = wx_re_reg;
            2'd1:    w_sel = wx_im_reg;
            2'd2:    w_sel = wy_re_reg;
            default: w_sel = wy_im_reg;
        endcase
    end

    assign mul_a = cmd.cnt[0] ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_b = cmd.cnt[1] ? inv2_reg[63:32] : inv2_reg[31:0];
    assign pp    = mul_a * mul_b;

    always_comb
    begin
        case (cmd.cnt)
            2'd0:    pp_shifted = PROD_W'(pp);
            2'd3:    pp_shifted = {pp, 64'd0};
            default: pp_shifted = {32'd0, pp, 32'd0};
        endcase
    end

    // Eight quotient bits per cycle by restoring steps on a narrow remainder.
    assign dvs = stencil_divisor(order_reg);

    always_comb
    begin
        div_src = cmd.div_first ? prod_reg[PROD_W-1:PROD_W-QUOT_W] : div_reg;
        part    = cmd.div_first ? '0 : {1'b0, rem_reg};
        qdig    = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            part = {part[DIGIT_W-1:0], div_src[QUOT_W-DIGIT_W+i]};
            if (part >= {1'b0, dvs})
            begin
                part    = part - {1'b0, dvs};
                qdig[i] = 1'b1;
            end
        end
    end

    assign term_val = neg_reg ? -$signed({2'b00, div_reg}) : $signed({2'b00, div_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            inv2_reg <= cmd.term[1] ? inv_dy_reg * inv_dy_reg : inv_dx_reg * inv_dx_reg;
            neg_reg  <= w_sel[WW-1];
            mag_reg  <= 64'(w_sel[WW-1] ? -w_sel : w_sel);
            prod_reg <= '0;
        end
        if (cmd.mult)
        begin
            prod_reg <= prod_reg + pp_shifted;
        end
        if (cmd.div)
        begin
            div_reg <= {div_src[QUOT_W-DIGIT_W-1:0], qdig};
            rem_reg <= part[DIGIT_W-1:0];
        end
        if (cmd.load)
        begin
            sum_re_reg <= '0;
            sum_im_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (cmd.term[0])
            begin
                sum_im_reg <= sum_im_reg + term_val;
            end
            else
            begin
                sum_re_reg <= sum_re_reg + term_val;
            end
        end
    end

    function automatic logic signed [63:0] sat64(input logic signed [TERM_W-1:0] v);
        logic signed [63:0] r;
        if (v[TERM_W-1:63] == '0 || v[TERM_W-1:63] == '1)
        begin
            r = v[63:0];
        end
        else
        begin
            r = v[TERM_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            lap_re     <= err_reg ? 64'sd0 : sat64(sum_re_reg);
            lap_im     <= err_reg ? 64'sd0 : sat64(sum_im_reg);
            addr_error <= err_reg;
        end
    end

    assign status.order = order_reg;
    assign status.err   = err_reg;

endmodule

FILE: rtl/complex_grid_laplacian_stencil_top.sv
// ============================================================================
// Complex grid Laplacian stencil, top level
// Stores a complex grid and returns its finite-difference Laplacian on query.
// ============================================================================
// Usage. A request beat is taken at a rising edge with start high and busy
// low. A write request (req_type 0) stores sample_re and sample_im at
// row*row_stride+col in the same edge and leaves the block idle, so writes
// may follow each other in every cycle. A query request (req_type 1) raises
// busy and later returns one result beat: lap_re, lap_im and addr_error are
// valid for the single cycle in which done is high.
// A query first reads its taps of both axes through the shared read port,
// then each of the four axis terms squares the spacing, sums 32 by 32
// partial products and passes through the eight-bit-per-cycle divider.
// A query that meets an address outside the store ends after its reads,
// and order zero answers without reads. One query is in flight at a time;
// busy falls as done rises, so the next request may be taken then.
// The receiver cannot stall: each result beat is shown once.
// Reset clears the controller and loads the register reset values; the
// sample stores are not cleared and must be written before they are read.
// Configuration is to be written through cfg_we, cfg_index and cfg_data
// while idle, a duty of the user that the block itself leaves unenforced.
// ============================================================================
module complex_grid_laplacian_stencil_top
#(
    parameter int GRID_WORDS  = 4096,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [5:0]                          row,
    input  logic [5:0]                          col,
    input  logic signed [31:0]                  sample_re,
    input  logic signed [31:0]                  sample_im,
    output logic                                done,
    output logic signed [63:0]                  lap_re,
    output logic signed [63:0]                  lap_im,
    output logic                                addr_error,
    input  logic                                cfg_we,
    input  logic [cgls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cgls_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cgls_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       ctrl_start;

    // The controller only sees a request while it is idle.
    assign ctrl_start = start && !busy;

    cgls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl_start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    cgls_datapath
    #(
        .GRID_WORDS  (GRID_WORDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .row        (row),
        .col        (col),
        .sample_re  (sample_re),
        .sample_im  (sample_im),
        .done       (done),
        .lap_re     (lap_re),
        .lap_im     (lap_im),
        .addr_error (addr_error)
    );

`ifndef NO_ASSERTIONS
    // A result beat lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted query always occupies the block.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_QUERY) |=> busy)
        else $error("query accepted without raising busy");

    // A write never occupies the block.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_WRITE) |=> !busy)
        else $error("write request stalled the block");

    // Every query ends with a result beat in the cycle busy falls.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without a result beat");

    // A result is only shown once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");
`endif

endmodule
